// ===== rtl/core/owt_pkg.sv =====
// Shared types, codes, constants and CRC helpers for the 1-Wire thermometer command layer.
package owt_pkg;

    // Busy timer lengths in one-millisecond ticks
    localparam int FULL_CONVERT_MS = 750;
    localparam int COPY_MS         = 10;
    localparam int BUSY_W          = 10;

    // Scratchpad geometry
    localparam int SP_DEPTH = 9;
    localparam int BC_W     = 4;

    // Function command codes
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_COPY     = 8'h48;
    localparam logic [7:0] CMD_WRITE_SP = 8'h4E;
    localparam logic [7:0] CMD_READ_PWR = 8'hB4;
    localparam logic [7:0] CMD_RECALL   = 8'hB8;
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;

    localparam logic [7:0] STATUS_CODE = 8'h32;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] SET_MASK    = 8'h60;
    localparam logic [7:0] SET_FILL    = 8'h1F;

    // Stored (EEPROM) reset contents
    localparam logic [7:0] STORED_TH_INIT  = 8'h1E;
    localparam logic [7:0] STORED_TL_INIT  = 8'hFB;
    localparam logic [7:0] STORED_SET_INIT = 8'h7F;

    localparam logic [7:0] SP_INIT [8] = '{8'hAA, 8'h00, 8'h1E, 8'hFB,
                                           8'hFF, 8'hFF, 8'h0C, 8'h10};

    // Configuration register indexes
    localparam logic CFG_POWER   = 1'b0;
    localparam logic CFG_VARIANT = 1'b1;

    typedef enum logic [1:0] {
        MODE_RESET,
        MODE_WRITE,
        MODE_READ,
        MODE_TICK
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_WRITE,
        PH_SCRATCH,
        PH_PARASITE,
        PH_POLL,
        PH_DONE,
        PH_CODE
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CRC,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic crc_step;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_crc;
        logic crc_last;
    } dp_status_t;

    // One byte through the reflected x^8+x^5+x^4+1 CRC; c already holds crc ^ data
    function automatic logic [7:0] crc8_byte(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        for (int b = 0; b < 8; b++) begin
            v = v[0] ? ((v >> 1) ^ 8'h8C) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [7:0] crc8_init();
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < 8; i++) begin
            c = crc8_byte(c ^ SP_INIT[i]);
        end
        return c;
    endfunction

    localparam logic [7:0] SP_CRC_INIT = crc8_init();

endpackage

// ===== rtl/core/owt_ctrl.sv =====
// Sequencer: input/output handshakes and the execute, CRC and deliver steps.
module owt_ctrl import owt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EXEC;
            ST_EXEC: state_next = status.need_crc ? ST_CRC : ST_DONE;
            ST_CRC:  if (status.crc_last) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: cmd.load     = in_valid;
            ST_EXEC: cmd.exec     = 1'b1;
            ST_CRC:  cmd.crc_step = 1'b1;
            ST_DONE: cmd.out_load = out_free;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_EXEC)
        else $error("accepted item not executed next cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while full");

    a_crc_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CRC && status.crc_last |=> state_reg == ST_DONE)
        else $error("CRC pass did not end");

endmodule

// ===== rtl/core/owt_dp.sv =====
// Datapath: scratchpad, stored bytes, bus phase, busy timer, CRC unit, result register.
module owt_dp import owt_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_cmd_t            cmd,
    output dp_status_t          status,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic                cfg_data,
    input  logic [1:0]          mode,
    input  logic [7:0]          write_byte,
    input  logic signed [11:0]  temperature,
    output logic [7:0]          read_byte,
    output logic                read_driven,
    output logic                busy_res,
    output logic                alarm
);

    // latched item
    mode_t              mode_reg;
    logic [7:0]         wb_reg;
    logic signed [11:0] temp_reg;

    // model state
    logic [7:0]        scratch_reg [SP_DEPTH];
    logic [7:0]        scratch_next [SP_DEPTH];
    logic [7:0]        th_reg, th_next, tl_reg, tl_next, set_reg, set_next;
    phase_t            phase_reg, phase_next;
    logic [BC_W-1:0]   bc_reg, bc_next;
    logic [BUSY_W-1:0] busy_reg, busy_next;
    logic              loaded_reg, loaded_next;
    logic [7:0]        hold_reg [2];
    logic [7:0]        hold_next [2];
    logic              ext_pow_reg, ext_var_reg;

    // step result and CRC unit
    logic [7:0] rb_reg, rb_next;
    logic       drv_reg, drv_next;
    logic [7:0] crc_reg, crc_next, crc_byte;
    logic [2:0] crc_idx_reg, crc_idx_next;
    logic       need_crc;

    // output register
    logic [7:0] read_byte_reg;
    logic       read_driven_reg, busy_res_reg, alarm_reg;

    logic [BC_W-1:0] rd_addr;
    logic [7:0]      rd_data;

    // recall values and the scratchpad bytes as seen by the command
    logic [7:0] rec4, eff2, eff3, eff4;
    logic [1:0] res_m;

    // conversion
    logic signed [12:0] s_val, s_adj;
    logic [9:0]         q_val;
    logic [7:0]         conv_b1, conv_b6;
    logic [BUSY_W-1:0]  conv_shift, conv_ms;

    logic [7:0] alarm_t;
    logic       alarm_now;

    assign rd_addr  = cmd.crc_step ? {1'b0, crc_idx_reg} : bc_reg;
    assign rd_data  = (rd_addr < BC_W'(SP_DEPTH)) ? scratch_reg[rd_addr] : IDLE_BYTE;
    assign crc_byte = crc8_byte(crc_reg ^ rd_data);

    assign rec4 = ext_var_reg ? ((set_reg & SET_MASK) | SET_FILL) : scratch_reg[4];
    assign eff2 = loaded_reg ? scratch_reg[2] : th_reg;
    assign eff3 = loaded_reg ? scratch_reg[3] : tl_reg;
    assign eff4 = loaded_reg ? scratch_reg[4] : rec4;
    assign res_m = eff4[6:5];

    // half degrees: temperature plus 4, divided by 8 truncated toward zero
    assign s_val   = {temp_reg[11], temp_reg} + 13'sd4;
    assign s_adj   = s_val[12] ? (s_val + 13'sd7) : s_val;
    assign q_val   = s_adj[12:3];
    assign conv_b1 = q_val[9] ? 8'hFF : (q_val[8] ? 8'h01 : 8'h00);
    // 16 minus the signed remainder of s by 16, or zero when res_m is 0
    assign conv_b6 = (res_m == 2'd0) ? 8'h00 :
                     (s_val[12] && (s_val[3:0] != 4'd0)) ? (8'd32 - {4'd0, s_val[3:0]}) :
                     (8'd16 - {4'd0, s_val[3:0]});
    assign conv_shift = BUSY_W'(FULL_CONVERT_MS) >> (2'd3 - res_m);
    assign conv_ms    = (conv_shift == '0) ? BUSY_W'(1) : conv_shift;

    assign alarm_t   = {(scratch_reg[1] != 8'h00), scratch_reg[0][7:1]};
    assign alarm_now = ($signed(alarm_t) < $signed(scratch_reg[3])) ||
                       ($signed(alarm_t) > $signed(scratch_reg[2]));

    always_comb
    begin
        scratch_next    = scratch_reg;
        th_next         = th_reg;
        tl_next         = tl_reg;
        set_next        = set_reg;
        phase_next      = phase_reg;
        bc_next         = bc_reg;
        busy_next       = busy_reg;
        loaded_next     = loaded_reg;
        hold_next       = hold_reg;
        rb_next         = rb_reg;
        drv_next        = drv_reg;
        crc_next        = crc_reg;
        crc_idx_next    = crc_idx_reg;
        need_crc        = 1'b0;

        if (cmd.exec)
        begin
            rb_next      = IDLE_BYTE;
            drv_next     = 1'b0;
            crc_next     = 8'h00;
            crc_idx_next = 3'd0;
            unique case (mode_reg)
                MODE_RESET:
                begin
                    phase_next = PH_CMD;
                    bc_next    = '0;
                end
                MODE_WRITE:
                begin
                    if (phase_reg == PH_CMD)
                    begin
                        // first command after reset pulls in the stored bytes
                        if (!loaded_reg)
                        begin
                            loaded_next     = 1'b1;
                            scratch_next[2] = th_reg;
                            scratch_next[3] = tl_reg;
                            scratch_next[4] = rec4;
                            need_crc        = 1'b1;
                        end
                        bc_next    = '0;
                        phase_next = PH_CODE;
                        unique case (wb_reg)
                            CMD_CONVERT:
                            begin
                                scratch_next[0] = q_val[7:0];
                                scratch_next[1] = conv_b1;
                                scratch_next[6] = conv_b6;
                                need_crc        = 1'b1;
                                if (ext_pow_reg)
                                begin
                                    busy_next  = conv_ms;
                                    phase_next = PH_POLL;
                                end
                            end
                            CMD_COPY:
                            begin
                                th_next = eff2;
                                tl_next = eff3;
                                if (ext_var_reg)
                                    set_next = eff4;
                                if (ext_pow_reg)
                                begin
                                    busy_next  = BUSY_W'(COPY_MS);
                                    phase_next = PH_POLL;
                                end
                            end
                            CMD_WRITE_SP: phase_next = PH_WRITE;
                            CMD_READ_PWR: phase_next = ext_pow_reg ? PH_DONE : PH_PARASITE;
                            CMD_RECALL:
                            begin
                                scratch_next[2] = th_reg;
                                scratch_next[3] = tl_reg;
                                scratch_next[4] = rec4;
                                need_crc        = 1'b1;
                            end
                            CMD_READ_SP: phase_next = PH_SCRATCH;
                            default: phase_next = PH_CODE;
                        endcase
                    end
                    else if (phase_reg == PH_WRITE)
                    begin
                        if (bc_reg < (ext_var_reg ? BC_W'(2) : BC_W'(1)))
                        begin
                            hold_next[bc_reg[0]] = wb_reg;
                            bc_next = bc_reg + BC_W'(1);
                        end
                        else
                        begin
                            scratch_next[2] = hold_reg[0];
                            if (ext_var_reg)
                            begin
                                scratch_next[3] = hold_reg[1];
                                scratch_next[4] = (wb_reg & SET_MASK) | SET_FILL;
                            end
                            else
                            begin
                                scratch_next[3] = wb_reg;
                            end
                            need_crc   = 1'b1;
                            bc_next    = '0;
                            phase_next = PH_DONE;
                        end
                    end
                end
                MODE_READ:
                begin
                    unique case (phase_reg)
                        PH_SCRATCH:
                        begin
                            if (bc_reg < BC_W'(SP_DEPTH))
                            begin
                                rb_next  = rd_data;
                                drv_next = 1'b1;
                                bc_next  = bc_reg + BC_W'(1);
                            end
                            if (bc_reg >= BC_W'(SP_DEPTH - 1))
                                phase_next = PH_DONE;
                        end
                        PH_CODE:
                        begin
                            rb_next    = STATUS_CODE;
                            drv_next   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        PH_PARASITE:
                        begin
                            rb_next  = 8'h00;
                            drv_next = 1'b1;
                        end
                        PH_POLL:
                        begin
                            if (busy_reg != '0)
                            begin
                                rb_next  = 8'h00;
                                drv_next = 1'b1;
                            end
                        end
                        default: rb_next = IDLE_BYTE;
                    endcase
                end
                default:
                begin
                    if (busy_reg != '0)
                        busy_next = busy_reg - BUSY_W'(1);
                end
            endcase
        end

        if (cmd.crc_step)
        begin
            crc_next     = crc_byte;
            crc_idx_next = crc_idx_reg + 3'd1;
            if (crc_idx_reg == 3'd7)
                scratch_next[8] = crc_byte;
        end
    end

    assign status = '{need_crc: need_crc, crc_last: (crc_idx_reg == 3'd7)};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode_t'(mode);
            wb_reg   <= write_byte;
            temp_reg <= temperature;
        end
        if (cmd.out_load)
        begin
            read_byte_reg   <= rb_reg;
            read_driven_reg <= drv_reg;
            busy_res_reg    <= (busy_reg != '0);
            alarm_reg       <= alarm_now;
        end
        rb_reg      <= rb_next;
        drv_reg     <= drv_next;
        crc_reg     <= crc_next;
        crc_idx_reg <= crc_idx_next;
        hold_reg    <= hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                scratch_reg[i] <= SP_INIT[i];
            end
            scratch_reg[8] <= SP_CRC_INIT;
            th_reg      <= STORED_TH_INIT;
            tl_reg      <= STORED_TL_INIT;
            set_reg     <= STORED_SET_INIT;
            phase_reg   <= PH_IDLE;
            bc_reg      <= '0;
            busy_reg    <= '0;
            loaded_reg  <= 1'b0;
            ext_pow_reg <= 1'b1;
            ext_var_reg <= 1'b0;
        end
        else
        begin
            scratch_reg <= scratch_next;
            th_reg      <= th_next;
            tl_reg      <= tl_next;
            set_reg     <= set_next;
            phase_reg   <= phase_next;
            bc_reg      <= bc_next;
            busy_reg    <= busy_next;
            loaded_reg  <= loaded_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POWER:   ext_pow_reg <= cfg_data;
                    CFG_VARIANT: ext_var_reg <= cfg_data;
                    default:     ext_var_reg <= ext_var_reg;
                endcase
            end
        end
    end

    assign read_byte   = read_byte_reg;
    assign read_driven = read_driven_reg;
    assign busy_res    = busy_res_reg;
    assign alarm       = alarm_reg;

    a_sp_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SCRATCH |-> bc_reg < BC_W'(SP_DEPTH))
        else $error("scratchpad read index past end while reading");

    a_tick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && mode_reg == MODE_TICK && busy_reg != '0
        |=> busy_reg == $past(busy_reg) - BUSY_W'(1))
        else $error("busy timer did not count down on tick");

    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> busy_reg == $past(busy_reg))
        else $error("busy timer changed outside an execute step");

endmodule

// ===== rtl/core/onewire_thermometer_commands.sv =====
// Top level of the 1-Wire thermometer function-command layer.
// Each input transfer is one bus event (bus reset, written byte, read slot or
// 1 ms tick) and yields exactly one result transfer. An item is accepted,
// executed and loaded into the result register, the load waiting until that
// register is free; when the event changes the scratchpad (convert, recall,
// scratchpad write, first command after reset) a bit-parallel CRC unit walks
// the eight scratchpad bytes one per cycle between execute and load. One
// item is in work at a time; the result register lets the next item be
// accepted while a finished result still waits for out_ready. Configuration
// (register 0 external power, register 1 extended variant) is always
// accepted and must be written only while the block is idle.
module onewire_thermometer_commands import owt_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic               cfg_data,
    // bus event channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [7:0]         write_byte,
    input  logic signed [11:0] temperature,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         read_byte,
    output logic               read_driven,
    output logic               busy_res,
    output logic               alarm
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    // configuration registers take a transfer on any cycle
    assign cfg_ready = 1'b1;

    owt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    owt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .write_byte  (write_byte),
        .temperature (temperature),
        .read_byte   (read_byte),
        .read_driven (read_driven),
        .busy_res    (busy_res),
        .alarm       (alarm)
    );

endmodule
